[sv/wobrs_pkg.sv]
package wobrs_pkg;

   // table size and register reset values
   localparam int MAX_OPTIONS_DEFAULT = 64;
   localparam logic [6:0] OPTIONS_IN_USE_RESET = 7'd45;
   localparam logic [15:0] COLD_START_MIN_RESET = 16'd10;

   // field widths
   localparam int WEIGHT_W = 16;
   localparam int COUNT_W = 32;
   localparam int RANDOM_W = 31;
   localparam int ENTRY_W = 6;
   localparam int HIST_W = 3 * COUNT_W;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 16;

   // op codes
   localparam logic [1:0] OP_WRITE_WEIGHT = 2'd0;
   localparam logic [1:0] OP_WRITE_HISTORY = 2'd1;
   localparam logic [1:0] OP_CHOOSE = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_OPTIONS_IN_USE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLD_START_MIN = 1'b1;

   typedef struct packed {
      logic [1:0] op;
      logic [ENTRY_W-1:0] entry_index;
      logic [WEIGHT_W-1:0] weight_value;
      logic [COUNT_W-1:0] success_count;
      logic [COUNT_W-1:0] failure_a_count;
      logic [COUNT_W-1:0] failure_b_count;
      logic [RANDOM_W-1:0] random_value;
      logic use_history;
   } req_word_type;

   typedef struct packed {
      logic [ENTRY_W-1:0] chosen_index;
      logic from_history;
      logic zero_weight_error;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HIST_READ,
      ST_HIST_SUM,
      ST_HIST_MUL_A,
      ST_HIST_MUL_B,
      ST_HIST_CMP,
      ST_HIST_DECIDE,
      ST_TOTAL_READ,
      ST_TOTAL_ADD,
      ST_TOTAL_CHECK,
      ST_MOD,
      ST_PICK_READ,
      ST_PICK_ADD,
      ST_DONE
   } state_type;

   // weight of an entry that was never written
   function automatic logic [WEIGHT_W-1:0] default_weight(input logic [7:0] idx);
      logic [WEIGHT_W-1:0] w;
      unique case (idx)
         8'd0: w = 16'd5;
         8'd6, 8'd10, 8'd11, 8'd17: w = 16'd100;
         8'd12, 8'd19: w = 16'd20;
         8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd8, 8'd9,
         8'd13, 8'd14, 8'd15, 8'd16,
         8'd20, 8'd21, 8'd22, 8'd23, 8'd24, 8'd25: w = 16'd10;
         default: w = 16'd0;
      endcase
      return w;
   endfunction

endpackage

[sv/weighted_or_best_ratio_selector_core.sv]
// Weighted-random or best-success-ratio option selector.
// req channel (req_valid/req_stall, req_word): op 0 writes one weight, op 1 writes
// one history entry (success, failure a, failure b), op 2 chooses an option. Writes
// give no response word. A choose gives one rsp word
// (rsp_valid/rsp_stall) with the chosen index and flags.
// csr channel (csr_valid/csr_ready, always ready): index 0 options_in_use,
// index 1 cold_start_min; write only while the block is idle.
// A choose, with n = min(options_in_use, MAX_OPTIONS), steps through:
//   history pass: per entry a memory read, count sum, two products on one
//   shared 32x34 multiplier and compare, then a decision state;
//   weighted pick: a read and an add per entry for the weight total, a check,
//   the bit-serial modulo, a read and an add per entry for the search (it stops
//   at the chosen entry), and a state to load the output.
// One item is worked on at a time; a new request is accepted only once the
// block is back in idle.
// Writes are accepted while a response word waits.
// Reset restores the register defaults and the default weights and clears all
// counts through per-entry valid bits; no clearing pass is needed.
// When rsp_stall is high the response word holds in its output register; the block
// accepts writes and one more choose, which finishes and waits for the register.
module weighted_or_best_ratio_selector_core #(
   parameter int MAX_OPTIONS = wobrs_pkg::MAX_OPTIONS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  wobrs_pkg::req_word_type                 req_word,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output wobrs_pkg::rsp_word_type                 rsp_word,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [wobrs_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [wobrs_pkg::CSR_DATA_W-1:0]        csr_data
);

   localparam int IDX_W = $clog2(MAX_OPTIONS);
   localparam int CNT_W = $clog2(MAX_OPTIONS + 1);
   localparam int WSUM_W = wobrs_pkg::WEIGHT_W + $clog2(MAX_OPTIONS);
   localparam int CW = wobrs_pkg::COUNT_W;
   localparam int SUM_W = CW + 2;
   localparam int PROD_W = CW + SUM_W;
   localparam int RW = wobrs_pkg::RANDOM_W;
   localparam int BIT_W = $clog2(RW);

   // configuration registers
   logic [6:0]  options_ff;
   logic [15:0] cold_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         options_ff <= wobrs_pkg::OPTIONS_IN_USE_RESET;
         cold_ff <= wobrs_pkg::COLD_START_MIN_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == wobrs_pkg::CSR_OPTIONS_IN_USE) begin
            options_ff <= csr_data[6:0];
         end else if (csr_index == wobrs_pkg::CSR_COLD_START_MIN) begin
            cold_ff <= csr_data;
         end
      end
   end

   // entries in use, clipped to the table size
   logic [8:0]       options_ext;
   logic [CNT_W-1:0] n_use;
   assign options_ext = 9'(options_ff);
   assign n_use = (options_ext > 9'(MAX_OPTIONS)) ? CNT_W'(MAX_OPTIONS) : CNT_W'(options_ext);

   // state
   wobrs_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]  i_ff, i_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [RW-1:0]     rnd_ff, rnd_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic [CW-1:0]     hist_total_ff, hist_total_in;
   logic [IDX_W-1:0]  best_ff, best_in;
   logic [CW-1:0]     best_s_ff, best_s_in;
   logic [SUM_W-1:0]  best_n_ff, best_n_in;
   logic [CW-1:0]     s_ff, s_in;
   logic [SUM_W-1:0]  cnt_ff, cnt_in;
   logic [PROD_W-1:0] prod_a_ff, prod_a_in;
   logic [PROD_W-1:0] prod_b_ff, prod_b_in;
   logic [WSUM_W-1:0] wsum_ff, wsum_in;
   logic [WSUM_W-1:0] wtotal_ff, wtotal_in;
   logic [WSUM_W-1:0] rem_ff, rem_in;
   wobrs_pkg::rsp_word_type res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   wobrs_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   // entry valid bits stand in for the reset contents of the memories
   logic [MAX_OPTIONS-1:0] wvld_ff;
   logic [MAX_OPTIONS-1:0] hvld_ff;

   // memories
   logic                         w_wr_en, h_wr_en;
   logic [IDX_W-1:0]             wr_addr;
   logic [IDX_W-1:0]             rd_addr;
   logic [wobrs_pkg::WEIGHT_W-1:0] w_rd_data;
   logic [wobrs_pkg::HIST_W-1:0] h_rd_data;

   assign rd_addr = i_ff[IDX_W-1:0];
   assign wr_addr = IDX_W'(req_word.entry_index);

   wobrs_ram #(
      .WIDTH(wobrs_pkg::WEIGHT_W),
      .DEPTH(MAX_OPTIONS)
   ) u_weight_ram (
      .clock  (clock),
      .wr_en  (w_wr_en),
      .wr_addr(wr_addr),
      .wr_data(req_word.weight_value),
      .rd_addr(rd_addr),
      .rd_data(w_rd_data)
   );

   wobrs_ram #(
      .WIDTH(wobrs_pkg::HIST_W),
      .DEPTH(MAX_OPTIONS)
   ) u_history_ram (
      .clock  (clock),
      .wr_en  (h_wr_en),
      .wr_addr(wr_addr),
      .wr_data({req_word.success_count, req_word.failure_a_count, req_word.failure_b_count}),
      .rd_addr(rd_addr),
      .rd_data(h_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wvld_ff <= '0;
         hvld_ff <= '0;
      end else begin
         if (w_wr_en) begin
            wvld_ff[wr_addr] <= 1'b1;
         end
         if (h_wr_en) begin
            hvld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // read data with never-written entries replaced by their reset values
   logic [wobrs_pkg::WEIGHT_W-1:0] w_cur;
   logic [CW-1:0] s_cur, fa_cur, fb_cur;
   assign w_cur = wvld_ff[rd_addr] ? w_rd_data : wobrs_pkg::default_weight(8'(rd_addr));
   assign s_cur = hvld_ff[rd_addr] ? h_rd_data[3*CW-1:2*CW] : '0;
   assign fa_cur = hvld_ff[rd_addr] ? h_rd_data[2*CW-1:CW] : '0;
   assign fb_cur = hvld_ff[rd_addr] ? h_rd_data[CW-1:0] : '0;

   // count sum and saturating history total
   logic [SUM_W-1:0] cnt_cur;
   logic [CW+2:0]    total_sum;
   assign cnt_cur = SUM_W'(s_cur) + SUM_W'(fa_cur) + SUM_W'(fb_cur);
   assign total_sum = (CW+3)'(hist_total_ff) + (CW+3)'(cnt_cur);

   // shared multiplier for the ratio cross products
   logic [CW-1:0]     mul_a;
   logic [SUM_W-1:0]  mul_b;
   logic [PROD_W-1:0] mul_p;
   assign mul_a = (state_ff == wobrs_pkg::ST_HIST_MUL_A) ? s_ff : best_s_ff;
   assign mul_b = (state_ff == wobrs_pkg::ST_HIST_MUL_A) ? best_n_ff : cnt_ff;
   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   // restoring modulo step and running weight sum
   logic [WSUM_W:0]   trial;
   logic [WSUM_W:0]   wsum_next;
   assign trial = {rem_ff, rnd_ff[RW-1]};
   assign wsum_next = (WSUM_W+1)'(wsum_ff) + (WSUM_W+1)'(w_cur);

   logic last_entry;
   assign last_entry = ((i_ff + CNT_W'(1)) == n_ff);

   logic req_accept;
   logic in_range;
   assign req_stall = (state_ff != wobrs_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign in_range = (9'(req_word.entry_index) < 9'(MAX_OPTIONS));

   // state register and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wobrs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff <= i_in;
      n_ff <= n_in;
      rnd_ff <= rnd_in;
      bit_ff <= bit_in;
      hist_total_ff <= hist_total_in;
      best_ff <= best_in;
      best_s_ff <= best_s_in;
      best_n_ff <= best_n_in;
      s_ff <= s_in;
      cnt_ff <= cnt_in;
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      wsum_ff <= wsum_in;
      wtotal_ff <= wtotal_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
      rsp_word_ff <= rsp_word_in;
   end

   // next state and datapath control
   always_comb begin
      state_in = state_ff;
      i_in = i_ff;
      n_in = n_ff;
      rnd_in = rnd_ff;
      bit_in = bit_ff;
      hist_total_in = hist_total_ff;
      best_in = best_ff;
      best_s_in = best_s_ff;
      best_n_in = best_n_ff;
      s_in = s_ff;
      cnt_in = cnt_ff;
      prod_a_in = prod_a_ff;
      prod_b_in = prod_b_ff;
      wsum_in = wsum_ff;
      wtotal_in = wtotal_ff;
      rem_in = rem_ff;
      res_in = res_ff;
      rsp_word_in = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      w_wr_en = 1'b0;
      h_wr_en = 1'b0;

      unique case (state_ff)
         wobrs_pkg::ST_IDLE: begin
            if (req_accept) begin
               i_in = '0;
               n_in = n_use;
               rnd_in = req_word.random_value;
               wsum_in = '0;
               if (req_word.op == wobrs_pkg::OP_WRITE_WEIGHT) begin
                  w_wr_en = in_range;
               end else if (req_word.op == wobrs_pkg::OP_WRITE_HISTORY) begin
                  h_wr_en = in_range;
               end else if (req_word.op == wobrs_pkg::OP_CHOOSE) begin
                  hist_total_in = '0;
                  best_in = '0;
                  best_s_in = '0;
                  best_n_in = SUM_W'(1);
                  if (req_word.use_history) begin
                     state_in = (n_use == '0) ? wobrs_pkg::ST_HIST_DECIDE
                                              : wobrs_pkg::ST_HIST_READ;
                  end else begin
                     state_in = (n_use == '0) ? wobrs_pkg::ST_TOTAL_CHECK
                                              : wobrs_pkg::ST_TOTAL_READ;
                  end
               end
            end
         end

         // history pass: best ratio and saturating total
         wobrs_pkg::ST_HIST_READ: begin
            state_in = wobrs_pkg::ST_HIST_SUM;
         end
         wobrs_pkg::ST_HIST_SUM: begin
            s_in = s_cur;
            cnt_in = cnt_cur;
            hist_total_in = (total_sum[CW+2:CW] != '0) ? '1 : total_sum[CW-1:0];
            state_in = wobrs_pkg::ST_HIST_MUL_A;
         end
         wobrs_pkg::ST_HIST_MUL_A: begin
            prod_a_in = mul_p;
            state_in = wobrs_pkg::ST_HIST_MUL_B;
         end
         wobrs_pkg::ST_HIST_MUL_B: begin
            prod_b_in = mul_p;
            state_in = wobrs_pkg::ST_HIST_CMP;
         end
         wobrs_pkg::ST_HIST_CMP: begin
            if ((cnt_ff != '0) && (prod_a_ff > prod_b_ff)) begin
               best_in = i_ff[IDX_W-1:0];
               best_s_in = s_ff;
               best_n_in = cnt_ff;
            end
            i_in = i_ff + CNT_W'(1);
            state_in = last_entry ? wobrs_pkg::ST_HIST_DECIDE : wobrs_pkg::ST_HIST_READ;
         end
         wobrs_pkg::ST_HIST_DECIDE: begin
            i_in = '0;
            wsum_in = '0;
            if (hist_total_ff >= CW'(cold_ff)) begin
               res_in.chosen_index = wobrs_pkg::ENTRY_W'(best_ff);
               res_in.from_history = 1'b1;
               res_in.zero_weight_error = 1'b0;
               state_in = wobrs_pkg::ST_DONE;
            end else begin
               state_in = (n_ff == '0) ? wobrs_pkg::ST_TOTAL_CHECK
                                       : wobrs_pkg::ST_TOTAL_READ;
            end
         end

         // weighted pick: total of weights
         wobrs_pkg::ST_TOTAL_READ: begin
            state_in = wobrs_pkg::ST_TOTAL_ADD;
         end
         wobrs_pkg::ST_TOTAL_ADD: begin
            wsum_in = wsum_next[WSUM_W-1:0];
            i_in = i_ff + CNT_W'(1);
            state_in = last_entry ? wobrs_pkg::ST_TOTAL_CHECK : wobrs_pkg::ST_TOTAL_READ;
         end
         wobrs_pkg::ST_TOTAL_CHECK: begin
            wtotal_in = wsum_ff;
            rem_in = '0;
            bit_in = BIT_W'(RW - 1);
            if (wsum_ff == '0) begin
               res_in.chosen_index = '0;
               res_in.from_history = 1'b0;
               res_in.zero_weight_error = 1'b1;
               state_in = wobrs_pkg::ST_DONE;
            end else begin
               state_in = wobrs_pkg::ST_MOD;
            end
         end

         // one remainder bit per cycle
         wobrs_pkg::ST_MOD: begin
            if (trial >= (WSUM_W+1)'(wtotal_ff)) begin
               rem_in = WSUM_W'(trial - (WSUM_W+1)'(wtotal_ff));
            end else begin
               rem_in = trial[WSUM_W-1:0];
            end
            rnd_in = {rnd_ff[RW-2:0], 1'b0};
            bit_in = bit_ff - BIT_W'(1);
            if (bit_ff == '0) begin
               i_in = '0;
               wsum_in = '0;
               state_in = wobrs_pkg::ST_PICK_READ;
            end
         end

         // first entry whose running sum exceeds the remainder
         wobrs_pkg::ST_PICK_READ: begin
            state_in = wobrs_pkg::ST_PICK_ADD;
         end
         wobrs_pkg::ST_PICK_ADD: begin
            wsum_in = wsum_next[WSUM_W-1:0];
            i_in = i_ff + CNT_W'(1);
            res_in.from_history = 1'b0;
            res_in.zero_weight_error = 1'b0;
            if (wsum_next > (WSUM_W+1)'(rem_ff)) begin
               res_in.chosen_index = wobrs_pkg::ENTRY_W'(i_ff[IDX_W-1:0]);
               state_in = wobrs_pkg::ST_DONE;
            end else if (last_entry) begin
               res_in.chosen_index = '0;
               state_in = wobrs_pkg::ST_DONE;
            end else begin
               state_in = wobrs_pkg::ST_PICK_READ;
            end
         end

         // hand the word to the output register once it is free
         wobrs_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_word_in = res_ff;
               rsp_valid_in = 1'b1;
               state_in = wobrs_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = wobrs_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

endmodule

[sv/wobrs_ram.sv]
module wobrs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[dv/tb.sv]
module tb;
   import wobrs_pkg::*;

   localparam int MAX_ENTRIES = 64;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_LIMIT = 50000;
   localparam longint LIMIT_CYCLES = 4000000;
   localparam int PHASE_ITEMS = 235;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // predictor state
   logic [WEIGHT_W-1:0] weight_mem [MAX_ENTRIES];
   logic [COUNT_W-1:0] success_mem [MAX_ENTRIES];
   logic [COUNT_W-1:0] fail_a_mem [MAX_ENTRIES];
   logic [COUNT_W-1:0] fail_b_mem [MAX_ENTRIES];
   logic [6:0] active_options;
   logic [15:0] cold_start_limit;
   rsp_word_type expected_picks [$];
   rsp_word_type want;

   int errors = 0;
   int table_writes = 0;
   int picks_checked = 0;
   int history_picks = 0;
   int zero_weight_picks = 0;
   int settings_used = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   longint cycle_count = 0;

   weighted_or_best_ratio_selector_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // clock
   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t timeout after %0d cycles", $time, cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // power-on table contents and registers
   function automatic void model_reset();
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         weight_mem[i] = (i >= 1 && i <= 25) ? 16'd10 : 16'd0;
         success_mem[i] = '0;
         fail_a_mem[i] = '0;
         fail_b_mem[i] = '0;
      end
      weight_mem[0] = 16'd5;
      weight_mem[7] = 16'd0;
      weight_mem[18] = 16'd0;
      weight_mem[6] = 16'd100;
      weight_mem[10] = 16'd100;
      weight_mem[11] = 16'd100;
      weight_mem[17] = 16'd100;
      weight_mem[12] = 16'd20;
      weight_mem[19] = 16'd20;
      active_options = 7'd45;
      cold_start_limit = 16'd10;
   endfunction

   function automatic int unsigned options_taking_part();
      return (32'(active_options) > MAX_ENTRIES) ? MAX_ENTRIES : 32'(active_options);
   endfunction

   // best success ratio when history is trusted, else weighted pick
   function automatic rsp_word_type predict_choice(input req_word_type w);
      rsp_word_type pick;
      int unsigned n, best, weight_sum, run, target;
      logic [127:0] best_succ, best_cnt, succ, cnt, lhs, rhs;
      longint unsigned seen;
      bit decided, found;
      pick = '0;
      decided = 0;
      found = 0;
      n = options_taking_part();
      if (w.use_history) begin
         best = 0;
         best_succ = '0;
         best_cnt = 128'd1;
         seen = 0;
         for (int i = 0; i < n; i++) begin
            succ = 128'(success_mem[i]);
            cnt = succ + 128'(fail_a_mem[i]) + 128'(fail_b_mem[i]);
            seen = seen + cnt[63:0];
            if (seen > 64'hFFFF_FFFF) seen = 64'hFFFF_FFFF;
            lhs = succ * best_cnt;
            rhs = best_succ * cnt;
            if (cnt != 0 && lhs > rhs) begin
               best = i;
               best_succ = succ;
               best_cnt = cnt;
            end
         end
         if (seen >= 64'(cold_start_limit)) begin
            pick.chosen_index = best[5:0];
            pick.from_history = 1'b1;
            decided = 1;
         end
      end
      if (!decided) begin
         weight_sum = 0;
         for (int i = 0; i < n; i++) weight_sum += 32'(weight_mem[i]);
         if (weight_sum == 0) begin
            pick.zero_weight_error = 1'b1;
         end else begin
            target = 32'(w.random_value) % weight_sum;
            run = 0;
            for (int i = 0; i < n; i++) begin
               run += 32'(weight_mem[i]);
               if (!found && run > target) begin
                  pick.chosen_index = i[5:0];
                  found = 1;
               end
            end
         end
      end
      return pick;
   endfunction

   // update tables or queue the expected pick for one accepted word
   function automatic void accept_word(input req_word_type w);
      rsp_word_type pick;
      case (w.op)
         OP_WRITE_WEIGHT: begin
            weight_mem[w.entry_index] = w.weight_value;
            table_writes++;
         end
         OP_WRITE_HISTORY: begin
            success_mem[w.entry_index] = w.success_count;
            fail_a_mem[w.entry_index] = w.failure_a_count;
            fail_b_mem[w.entry_index] = w.failure_b_count;
            table_writes++;
         end
         OP_CHOOSE: begin
            pick = predict_choice(w);
            if (pick.from_history) history_picks++;
            if (pick.zero_weight_error) zero_weight_picks++;
            expected_picks.push_back(pick);
         end
         default: ;
      endcase
   endfunction

   task automatic report_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
      if (exp_val != act_val) begin
         $display("%0t %s mismatch: expected %0d actual %0d", $time, name, exp_val,
                  act_val);
         errors++;
      end
   endtask

   // result checker and receiver stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_picks.size() == 0) begin
            $display("%0t unexpected result word: expected none actual %p", $time,
                     rsp_word);
            errors++;
         end else begin
            want = expected_picks.pop_front();
            picks_checked++;
            report_field("chosen_index", 32'(want.chosen_index),
                         32'(rsp_word.chosen_index));
            report_field("from_history", 32'(want.from_history),
                         32'(rsp_word.from_history));
            report_field("zero_weight_error", 32'(want.zero_weight_error),
                         32'(rsp_word.zero_weight_error));
         end
      end
      rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(99) < rsp_stall_pct);
   end

   // send one word, then maybe idle
   task automatic send_word(input req_word_type w);
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      accept_word(w);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   function automatic req_word_type make_word(input logic [1:0] op, input int unsigned idx,
                                              input logic [15:0] weight,
                                              input logic [31:0] succ,
                                              input logic [31:0] fail_a,
                                              input logic [31:0] fail_b,
                                              input logic [30:0] rnd, input logic hist);
      req_word_type w;
      w.op = op;
      w.entry_index = idx[5:0];
      w.weight_value = weight;
      w.success_count = succ;
      w.failure_a_count = fail_a;
      w.failure_b_count = fail_b;
      w.random_value = rnd;
      w.use_history = hist;
      return w;
   endfunction

   task automatic send_choose(input logic [30:0] rnd, input logic hist);
      send_word(make_word(OP_CHOOSE, 0, '0, '0, '0, '0, rnd, hist));
   endtask

   task automatic send_weight(input int unsigned idx, input logic [15:0] weight);
      send_word(make_word(OP_WRITE_WEIGHT, idx, weight, '0, '0, '0, '0, 1'b0));
   endtask

   task automatic send_history(input int unsigned idx, input logic [31:0] succ,
                               input logic [31:0] fail_a, input logic [31:0] fail_b);
      send_word(make_word(OP_WRITE_HISTORY, idx, '0, succ, fail_a, fail_b, '0, 1'b0));
   endtask

   // hold the sender until every pick is back and trailing writes are done
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_picks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_OPTIONS_IN_USE) active_options = data[6:0];
      else cold_start_limit = data;
      // let csr_valid fall before the next write
      @(posedge clock);
   endtask

   // random field values biased toward the interesting corners
   function automatic logic [31:0] random_count();
      case ($urandom_range(9))
         0, 1, 2: return 32'd0;
         3, 4, 5, 6: return $urandom_range(15);
         7: return $urandom_range(65535);
         8: return $urandom;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   function automatic logic [15:0] random_weight();
      logic [31:0] raw;
      raw = $urandom;
      case ($urandom_range(9))
         0, 1, 2: return 16'd0;
         3, 4, 5, 6: return 16'($urandom_range(1, 20));
         7, 8: return raw[15:0];
         default: return 16'hFFFF;
      endcase
   endfunction

   function automatic req_word_type random_word();
      req_word_type w;
      logic [31:0] raw;
      int unsigned roll, n;
      raw = $urandom;
      roll = $urandom_range(99);
      n = options_taking_part();
      if (roll < 28) w.op = OP_WRITE_WEIGHT;
      else if (roll < 52) w.op = OP_WRITE_HISTORY;
      else if (roll < 95) w.op = OP_CHOOSE;
      else w.op = OP_UNUSED;
      w.entry_index = raw[5:0];
      if (n > 0 && $urandom_range(99) < 80) w.entry_index = 6'($urandom_range(n - 1));
      w.weight_value = random_weight();
      w.success_count = random_count();
      w.failure_a_count = random_count();
      w.failure_b_count = random_count();
      raw = $urandom;
      w.random_value = ($urandom_range(3) == 0) ? 31'($urandom_range(200)) : raw[30:0];
      w.use_history = ($urandom_range(99) < 60);
      return w;
   endfunction

   // power-on weights, unused op, cold start falls back to weighted
   task automatic test_boot_weights();
      send_choose(31'd0, 1'b0);
      send_choose(31'd4, 1'b0);
      send_choose(31'd5, 1'b0);
      send_choose(31'h7FFF_FFFF, 1'b0);
      send_choose(31'd1234, 1'b1);
      send_word(make_word(OP_UNUSED, 63, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1));
      send_weight(63, 16'hFFFF);
      send_weight(7, 16'hFFFF);
      send_choose(31'd300, 1'b0);
   endtask

   // ratio search: ties, zero counts, saturation of the sum
   task automatic test_history_ratio();
      send_history(3, 32'd5, 32'd3, 32'd2);
      send_choose(31'd77, 1'b1);
      send_history(7, 32'd1, 32'd1, 32'd0);
      send_history(1, 32'd0, 32'd0, 32'd4);
      send_choose(31'd78, 1'b1);
      send_history(20, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_history(30, 32'hFFFF_FFFF, 32'd0, 32'd0);
      send_choose(31'd79, 1'b1);
      send_history(30, 32'd0, 32'd0, 32'd0);
      send_choose(31'd80, 1'b1);
   endtask

   // no options, too many options, extreme cold start limits
   task automatic test_register_edges();
      wait_idle();
      write_reg(CSR_OPTIONS_IN_USE, 16'd0);
      send_choose(31'd9, 1'b0);
      send_choose(31'd9, 1'b1);
      wait_idle();
      write_reg(CSR_COLD_START_MIN, 16'd0);
      send_choose(31'd9, 1'b1);
      wait_idle();
      write_reg(CSR_OPTIONS_IN_USE, 16'd127);
      write_reg(CSR_COLD_START_MIN, 16'hFFFF);
      send_choose(31'h7FFF_FFFE, 1'b0);
      send_choose(31'd11, 1'b1);
      settings_used += 3;
   endtask

   task automatic run_phase(input logic [15:0] opts, input logic [15:0] cold_min,
                            input int send_pct, input int stall_pct);
      req_word_type w;
      int counted;
      wait_idle();
      write_reg(CSR_OPTIONS_IN_USE, opts);
      write_reg(CSR_COLD_START_MIN, cold_min);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      settings_used++;
      counted = 0;
      while (counted < PHASE_ITEMS) begin
         w = random_word();
         send_word(w);
         if (w.op != OP_UNUSED) counted++;
         // let everything drain once mid-phase
         if (counted == PHASE_ITEMS / 2 && w.op != OP_UNUSED) wait_idle();
      end
   endtask

   // random traffic over several settings and idle patterns
   task automatic test_random_traffic();
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: run_phase(16'd64, 16'd0, 0, 0);
            1: run_phase(16'd3, 16'hFFFF, 61, 0);
            2: run_phase(16'd12, 16'd10, 0, 61);
            3: run_phase(16'd127, 16'($urandom_range(65535)), 10, 10);
            4: run_phase(16'd8, 16'd40, 0, 0);
            5: run_phase(16'd45, 16'd1, 61, 0);
            6: run_phase(16'd1, 16'd200, 0, 61);
            default: run_phase(16'd20, 16'd3, 10, 10);
         endcase
      end
   endtask

   initial begin
      int waited;
      model_reset();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_boot_weights();
      test_history_ratio();
      test_register_edges();
      test_random_traffic();

      // drain
      req_valid <= 1'b0;
      waited = 0;
      while (expected_picks.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_picks.size() != 0) begin
         $display("%0t %0d expected picks never arrived", $time, expected_picks.size());
         errors += expected_picks.size();
      end

      $display("covered %0d table writes and %0d picks over %0d register settings",
               table_writes, picks_checked, settings_used);
      $display("picks by history: %0d, zero total weight: %0d", history_picks,
               zero_weight_picks);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
